// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file that includes them.
// Each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/utf8d_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utf8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ---------------------------------------------------------------------------
package utf8d_pkg;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // Byte classification masks and patterns
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_PAT  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;

  // Results caused by one input byte: a run of replacements, then
  // optionally one final code point.
  typedef struct packed {
    logic [1:0]      rep_cnt;
    logic            has_final;
    logic [CP_W-1:0] final_cp;
  } desc_t;

endpackage
`default_nettype wire

// ===== rtl/utf8d_decode.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utf8d_decode
// Sequence state and per-byte decode into a registered result descriptor.
// ---------------------------------------------------------------------------
module utf8d_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_valid,
  output logic                   byte_ready,
  input  wire logic [7:0]        byte_in,
  output logic                   desc_valid,
  input  wire logic              desc_ready,
  output utf8d_pkg::desc_t       desc
);
  import utf8d_pkg::*;

  logic [CP_W-1:0] pv_r, pv_nxt;
  logic [1:0]      be_r, be_nxt;
  logic [1:0]      cs_r, cs_nxt;
  logic            dv_r, dv_nxt;
  desc_t           d_r, d_nxt;

  logic            accept;
  logic            pend;
  logic            is_cont;
  logic [1:0]      cs_inc;
  logic [CP_W-1:0] pv_shift;
  logic            lead_path;
  logic            nonempty;

  assign byte_ready = !dv_r || desc_ready;
  assign accept     = byte_valid && byte_ready;
  assign pend       = (be_r != 2'd0);
  assign is_cont    = ((byte_in & CONT_MASK) == CONT_PAT);
  assign cs_inc     = cs_r + 2'd1;
  assign pv_shift   = {pv_r[CP_W-7:0], byte_in[5:0]};

  // Next state and result descriptor for the byte on the input
  always_comb begin
    pv_nxt    = pv_r;
    be_nxt    = be_r;
    cs_nxt    = cs_r;
    d_nxt     = '0;
    lead_path = 1'b0;
    if (byte_in == 8'h00) begin
      // end of text: flush pending sequence
      d_nxt.rep_cnt = pend ? cs_inc : 2'd0;
      pv_nxt = '0;
      be_nxt = 2'd0;
      cs_nxt = 2'd0;
    end else if (pend && is_cont) begin
      if (cs_inc >= be_r) begin
        d_nxt.has_final = 1'b1;
        d_nxt.final_cp  = pv_shift;
        pv_nxt = '0;
        be_nxt = 2'd0;
        cs_nxt = 2'd0;
      end else begin
        pv_nxt = pv_shift;
        cs_nxt = cs_inc;
      end
    end else begin
      // broken sequence drops pending bytes, then decodes as lead
      d_nxt.rep_cnt = pend ? cs_inc : 2'd0;
      pv_nxt = '0;
      be_nxt = 2'd0;
      cs_nxt = 2'd0;
      lead_path = 1'b1;
    end

    if (lead_path) begin
      if (byte_in[7] == 1'b0) begin
        d_nxt.has_final = 1'b1;
        d_nxt.final_cp  = {{(CP_W-8){1'b0}}, byte_in};
      end else if ((byte_in & LEAD2_MASK) == LEAD2_PAT) begin
        pv_nxt = {{(CP_W-5){1'b0}}, byte_in[4:0]};
        be_nxt = 2'd1;
      end else if ((byte_in & LEAD3_MASK) == LEAD3_PAT) begin
        pv_nxt = {{(CP_W-4){1'b0}}, byte_in[3:0]};
        be_nxt = 2'd2;
      end else if ((byte_in & LEAD4_MASK) == LEAD4_PAT) begin
        pv_nxt = {{(CP_W-3){1'b0}}, byte_in[2:0]};
        be_nxt = 2'd3;
      end else begin
        d_nxt.has_final = 1'b1;
        d_nxt.final_cp  = REPL_CP;
      end
    end
  end

  assign nonempty = (d_nxt.rep_cnt != 2'd0) || d_nxt.has_final;

  // Descriptor stage occupancy
  always_comb begin
    dv_nxt = dv_r;
    if (accept) begin
      dv_nxt = nonempty;
    end else if (desc_ready) begin
      dv_nxt = 1'b0;
    end
  end

  // Sequence state and descriptor valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      be_r <= 2'd0;
      cs_r <= 2'd0;
      dv_r <= 1'b0;
    end else begin
      dv_r <= dv_nxt;
      if (accept) begin
        pv_r <= pv_nxt;
        be_r <= be_nxt;
        cs_r <= cs_nxt;
      end
    end
  end

  // Descriptor payload
  always_ff @(posedge clk) begin
    if (accept) begin
      d_r <= d_nxt;
    end
  end

  assign desc_valid = dv_r;
  assign desc       = d_r;

endmodule
`default_nettype wire

// ===== rtl/utf8d_emit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utf8d_emit
// Output register that plays one descriptor out as its result transfers.
// ---------------------------------------------------------------------------
module utf8d_emit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       desc_valid,
  output logic                            desc_ready,
  input  wire utf8d_pkg::desc_t           desc,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [utf8d_pkg::CP_W-1:0]      out_cp,
  output logic                            out_last
);
  import utf8d_pkg::*;

  logic [1:0]      rep_r, rep_nxt;
  logic            fin_r, fin_nxt;
  logic [CP_W-1:0] cp_r;
  logic            busy;
  logic            xfer;
  logic            load;

  assign busy = (rep_r != 2'd0) || fin_r;

  // Current item: replacements first, final code point last
  always_comb begin
    if (rep_r != 2'd0) begin
      out_cp   = REPL_CP;
      out_last = (rep_r == 2'd1) && !fin_r;
    end else begin
      out_cp   = cp_r;
      out_last = 1'b1;
    end
  end

  assign out_valid  = busy;
  assign xfer       = out_valid && out_ready;
  assign desc_ready = !busy || (xfer && out_last);
  assign load       = desc_valid && desc_ready;

  // Item counters
  always_comb begin
    rep_nxt = rep_r;
    fin_nxt = fin_r;
    if (load) begin
      rep_nxt = desc.rep_cnt;
      fin_nxt = desc.has_final;
    end else if (xfer) begin
      if (out_last) begin
        rep_nxt = 2'd0;
        fin_nxt = 1'b0;
      end else begin
        rep_nxt = rep_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r <= 2'd0;
      fin_r <= 1'b0;
    end else begin
      rep_r <= rep_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r <= desc.final_cp;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/utf8_stream_decoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming UTF-8 to code point decoder.
// ---------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one text byte per transfer; byte 0 ends the text,
//   flushes any pending sequence as U+FFFD results and clears the state.
//   The out_ channel gives code points, one per transfer; out_tlast marks
//   the final result caused by one input byte. Bytes that only extend a
//   sequence give no result.
//   Each result passes the descriptor register, then the output register.
//   Throughput: one input byte per cycle while each byte causes at most one
//   result and the receiver does not stall; a byte that causes k results
//   occupies the output for k transfers (k is 0 to 4, set by the replacement
//   run of a broken sequence). The descriptor register decouples the two
//   sides, so one more byte that causes a result is taken while a result
//   waits on a stalled receiver; further such bytes wait.
//   Reset (rst_n low, synchronous) clears the sequence state and drops all
//   pending results. A stalled output holds its value and out_tlast.
// ---------------------------------------------------------------------------
module utf8_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [20:0] code_point, [23:21] zero
  output logic             out_tlast   // last
);
  import utf8d_pkg::*;

  logic            desc_valid;
  logic            desc_ready;
  desc_t           desc;
  logic [CP_W-1:0] cp;

  // Byte decode and sequence state
  utf8d_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_ready (in_tready),
    .byte_in    (in_tdata),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc)
  );

  // Result serializer
  utf8d_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cp     (cp),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{(24-CP_W){1'b0}}, cp};

endmodule
`default_nettype wire

// ===== rtl/utf8d_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// utf8d_checker
// Port-level checks for the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8d_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);

  // Synchronous reset empties the output
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "output valid after reset")

  // Stalled result is held
  `ASSERT_CLK(a_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast),
    "stalled result changed")

  // Only replacements precede the final result of a byte
  `ASSERT_CLK(a_rep_run, clk, rst_n,
    out_tvalid && !out_tlast |-> out_tdata == 24'h00FFFD,
    "non-final result is not U+FFFD")

  // An ASCII byte reaching an idle output starts its results after the descriptor
  // and output registers; a broken pending sequence puts replacements ahead of it
  `ASSERT_CLK(a_ascii, clk, rst_n,
    in_tvalid && in_tready && !out_tvalid && in_tdata[7] == 1'b0 && in_tdata != 8'h00
      ##1 !out_tvalid |=> out_tvalid &&
      (out_tlast ? out_tdata == {16'h0000, $past(in_tdata, 2)} : out_tdata == 24'h00FFFD),
    "ASCII byte not passed through")

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== tb/sv/utf8_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf8_checker
// Watches both channels of the UTF-8 stream decoder. Every accepted byte runs
// through a local copy of the sequence state, which queues the code points
// that byte should cause. Each result transfer is then compared with the
// oldest queued code point.
// ---------------------------------------------------------------------------
module utf8_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  input  wire logic        out_tlast,  // last
  output int               fail_count,
  output int               n_pending,
  output int               n_bytes,
  output int               n_results,
  output int               n_repl,
  output int               n_bursts
);
  import utf8d_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } cp_item_t;

  // expected code points, oldest first
  cp_item_t cp_expected [$];

  // local copy of the sequence state
  logic [CP_W-1:0] seq_value = '0;
  logic [1:0]      seq_need  = 2'd0;
  logic [1:0]      seq_seen  = 2'd0;

  initial begin
    fail_count = 0;
    n_pending  = 0;
    n_bytes    = 0;
    n_results  = 0;
    n_repl     = 0;
    n_bursts   = 0;
  end

  task automatic expect_cp(input logic [CP_W-1:0] cp);
    cp_expected.push_back('{cp: cp, last: 1'b0});
  endtask

  task automatic clear_seq();
    seq_value = '0;
    seq_need  = 2'd0;
    seq_seen  = 2'd0;
  endtask

  // drop a pending sequence: one replacement for the lead, one per continuation
  task automatic flush_seq();
    int k;
    if (seq_need != 2'd0) begin
      expect_cp(REPL_CP);
      for (k = 0; k < int'(seq_seen); k++) expect_cp(REPL_CP);
    end
    clear_seq();
  endtask

  // byte seen with no sequence pending
  task automatic lead_byte(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      expect_cp({13'd0, b});
    end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      seq_value = {16'd0, b[4:0]};
      seq_need  = 2'd1;
      seq_seen  = 2'd0;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      seq_value = {17'd0, b[3:0]};
      seq_need  = 2'd2;
      seq_seen  = 2'd0;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      seq_value = {18'd0, b[2:0]};
      seq_need  = 2'd3;
      seq_seen  = 2'd0;
    end else begin
      // lone continuation or byte 0xF8 and above
      expect_cp(REPL_CP);
    end
  endtask

  // queue every code point one accepted byte causes; mark the final one
  task automatic decode_byte(input logic [7:0] b);
    int size0;
    size0 = cp_expected.size();
    if (b == 8'h00) begin
      // end of text
      flush_seq();
    end else if (seq_need != 2'd0) begin
      if ((b & CONT_MASK) == CONT_PAT) begin
        seq_value = {seq_value[CP_W-7:0], b[5:0]};
        seq_seen  = seq_seen + 2'd1;
        if (seq_seen >= seq_need) begin
          expect_cp(seq_value);
          clear_seq();
        end
      end else begin
        // broken sequence, then the byte starts over as a lead
        flush_seq();
        lead_byte(b);
      end
    end else begin
      lead_byte(b);
    end
    if (cp_expected.size() > size0)
      cp_expected[cp_expected.size()-1].last = 1'b1;
    if (cp_expected.size() - size0 > 1) n_bursts++;
  endtask

  // compare results first, then predict from the byte taken at this edge
  always @(posedge clk) begin
    cp_item_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (out_tdata[CP_W-1:0] == REPL_CP) n_repl++;
        if (cp_expected.size() == 0) begin
          $error("unexpected result: code_point %h, last %b",
                 out_tdata[CP_W-1:0], out_tlast);
          fail_count++;
        end else begin
          e = cp_expected.pop_front();
          if (out_tdata[CP_W-1:0] !== e.cp) begin
            $error("code_point: expected %h, got %h", e.cp, out_tdata[CP_W-1:0]);
            fail_count++;
          end
          if (out_tlast !== e.last) begin
            $error("last: expected %b, got %b", e.last, out_tlast);
            fail_count++;
          end
          if (out_tdata[23:CP_W] !== 3'd0) begin
            $error("tdata pad: expected %h, got %h", 3'd0, out_tdata[23:CP_W]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        n_bytes++;
        decode_byte(in_tdata);
      end
    end
    n_pending <= cp_expected.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the UTF-8 stream decoder. A directed burst covers
// field extremes and the error cases (lone continuation, invalid lead, broken
// sequence, end of text); random traffic, mostly well-formed multi-byte
// sequences, then runs under four idling patterns on both channels.
// ---------------------------------------------------------------------------
module tb;
  import utf8d_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer before giving up
  localparam int PHASE_ITEMS = 112;   // random bytes per idling phase

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic        out_tlast;

  int fail_count, n_pending, n_bytes, n_results, n_repl, n_bursts;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_sent         = 0;
  int idle_cycles    = 0;

  always #2 clk = ~clk;

  utf8_stream_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  utf8_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .n_pending  (n_pending),
    .n_bytes    (n_bytes),
    .n_results  (n_results),
    .n_repl     (n_repl),
    .n_bursts   (n_bursts)
  );

  // receiver: random backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("tb: errors");
        $finish;
      end
    end
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [7:0] lead_of(input int len);
    case (len)
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      4:       return {5'b11110, 3'($urandom)};
      default: return 8'($urandom_range(1, 127));
    endcase
  endfunction

  // sender stops until every expected result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // random text: mostly well-formed sequences, some broken ones and noise
  task automatic random_unit();
    int pick, len, k;
    pick = $urandom_range(99);
    if (pick < 68) begin
      len = $urandom_range(1, 4);
      send_byte(lead_of(len));
      for (k = 1; k < len; k++) send_byte(cont_byte());
    end else if (pick < 80) begin
      // truncated sequence followed by a byte that is not a continuation
      len = $urandom_range(2, 4);
      send_byte(lead_of(len));
      for (k = $urandom_range(0, len - 2); k > 0; k--) send_byte(cont_byte());
      if ($urandom_range(1)) send_byte({2'b11, 6'($urandom)});
      else send_byte({1'b0, 7'($urandom)});
    end else if (pick < 85) begin
      send_byte(8'h00);
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] directed [$];
    int ph;
    int target;
    int idle_tab [4];
    int stall_tab [4];

    idle_tab  = '{0, 51, 0, 27};
    stall_tab = '{0, 0, 51, 27};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every sequence length, error cases
    directed = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                 8'hF7, 8'hBF, 8'hBF, 8'hBF,   // largest code point
                 8'h80, 8'hF8, 8'hFF,          // lone continuation, invalid leads
                 8'hF0, 8'h80, 8'h80, 8'h41,   // broken 4-byte sequence
                 8'hF0, 8'h90, 8'h80, 8'h00,   // end of text mid-sequence
                 8'hC3, 8'hF8};                // broken, then invalid lead
    foreach (directed[i]) send_byte(directed[i]);
    drain();

    // random traffic under each idling pattern
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      target = n_sent + PHASE_ITEMS;
      while (n_sent < target) random_unit();
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("summary: %0d bytes decoded into %0d code points, %0d of them U+FFFD",
             n_bytes, n_results, n_repl);
    $display("summary: %0d bytes caused multi-result bursts, four idling patterns",
             n_bursts);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/utf8d_pkg.sv
rtl/utf8d_decode.sv
rtl/utf8d_emit.sv
rtl/utf8_stream_decoder.sv
rtl/utf8d_checker.sv
tb/sv/utf8_checker.sv
tb/sv/tb.sv
